>>> sv/ipc_pkg.sv
// interrupt priority controller shared types and constants
// operation codes, access sizes, request and result structs
// no dependencies
package ipc_pkg;

    localparam int unsigned ADDR_W = 24;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned LVL_W  = 3;
    localparam int unsigned VEC_W  = 8;
    localparam int unsigned PEND_W = 3;

    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned IN_TUSER_W  = 3;
    localparam int unsigned OUT_TDATA_W = 32;

    localparam logic [ADDR_W-1:0] ACK_ADDR    = 24'h3C000C;
    localparam logic [ADDR_W-1:0] ACK_ADDR_HI = 24'h3C000D;

    localparam logic [LVL_W-1:0] LVL_TOP    = 3'd7;
    localparam logic [LVL_W-1:0] LVL_RESET  = 3'd3;
    localparam logic [LVL_W-1:0] LVL_TIMER  = 3'd2;
    localparam logic [LVL_W-1:0] LVL_VBLANK = 3'd1;
    localparam logic [VEC_W-1:0] VEC_RESET  = 8'd27;
    localparam logic [VEC_W-1:0] VEC_TIMER  = 8'd26;
    localparam logic [VEC_W-1:0] VEC_VBLANK = 8'd25;

    localparam int unsigned PEND_RESET  = 0;
    localparam int unsigned PEND_TIMER  = 1;
    localparam int unsigned PEND_VBLANK = 2;

    typedef enum logic [2:0] {
        OP_REQ_VBLANK = 3'd0,
        OP_REQ_TIMER  = 3'd1,
        OP_REQ_RESET  = 3'd2,
        OP_BUS_WRITE  = 3'd3,
        OP_TAKE       = 3'd4,
        OP_SET_LEVEL  = 3'd5,
        OP_CLR_LEVEL  = 3'd6,
        OP_NONE       = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        SIZE_BYTE = 2'd0,
        SIZE_WORD = 2'd1,
        SIZE_LONG = 2'd2,
        SIZE_NONE = 2'd3
    } t_size;

    typedef struct packed {
        t_op                op;
        logic [ADDR_W-1:0]  address;
        logic [DATA_W-1:0]  write_data;
        t_size              access_size;
        logic [LVL_W-1:0]   cpu_mask;
        logic [LVL_W-1:0]   new_level;
        logic [VEC_W-1:0]   new_vector;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic [PEND_W-1:0]  mask;
    } t_ack;

    typedef struct packed {
        logic               granted;
        logic [LVL_W-1:0]   granted_level;
        logic [VEC_W-1:0]   granted_vector;
        logic [LVL_W-1:0]   level_now;
        logic [VEC_W-1:0]   vector_now;
        logic [PEND_W-1:0]  pending_now;
    } t_result;

endpackage

>>> sv/ipc_ack_decode.sv
// acknowledge register decode for byte, word and long bus writes
// long writes split into two words, words off the register into two bytes
// depends on ipc_pkg
module ipc_ack_decode (
    input  logic [ipc_pkg::ADDR_W-1:0] i_address,
    input  logic [ipc_pkg::DATA_W-1:0] i_write_data,
    input  ipc_pkg::t_size             i_access_size,
    output ipc_pkg::t_ack              o_ack
);
    import ipc_pkg::*;

    logic [ADDR_W-1:0] addr_lo;
    logic              hi_at_reg;
    logic              hi_at_odd;
    logic              lo_at_reg;
    logic              lo_at_odd;

    assign addr_lo   = i_address + ADDR_W'(2);
    assign hi_at_reg = (i_address == ACK_ADDR);
    assign hi_at_odd = (i_address == ACK_ADDR_HI);
    assign lo_at_reg = (addr_lo == ACK_ADDR);
    assign lo_at_odd = (addr_lo == ACK_ADDR_HI);

    always_comb begin
        o_ack = '0;
        unique case (i_access_size)
            SIZE_BYTE: begin
                o_ack.hit  = hi_at_odd;
                o_ack.mask = hi_at_odd ? i_write_data[2:0] : '0;
            end
            SIZE_WORD: begin
                o_ack.hit  = hi_at_reg || hi_at_odd;
                o_ack.mask = hi_at_reg ? i_write_data[2:0]
                           : (hi_at_odd ? i_write_data[10:8] : '0);
            end
            SIZE_LONG: begin
                // high half at the address, low half two bytes up
                o_ack.hit  = hi_at_reg || hi_at_odd || lo_at_reg || lo_at_odd;
                o_ack.mask = (hi_at_reg ? i_write_data[18:16] : '0)
                           | (hi_at_odd ? i_write_data[26:24] : '0)
                           | (lo_at_reg ? i_write_data[2:0]   : '0)
                           | (lo_at_odd ? i_write_data[10:8]  : '0);
            end
            default: o_ack = '0;
        endcase
    end

endmodule

>>> sv/ipc_state.sv
// pending bits, presented level and vector, edge flag for the top level
// updates the state for one request and forms its result
// depends on ipc_pkg
module ipc_state (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  ipc_pkg::t_req   i_req,
    input  ipc_pkg::t_ack   i_ack,
    output ipc_pkg::t_result o_result
);
    import ipc_pkg::*;

    logic [PEND_W-1:0] r_pending, n_pending;
    logic [LVL_W-1:0]  r_level, n_level;
    logic [VEC_W-1:0]  r_vector, n_vector;
    logic              r_edge, n_edge;
    logic              refresh;
    logic              grant;

    always_comb begin
        n_pending = r_pending;
        refresh   = 1'b0;
        case (i_req.op)
            OP_REQ_VBLANK: begin
                n_pending[PEND_VBLANK] = 1'b1;
                refresh = 1'b1;
            end
            OP_REQ_TIMER: begin
                n_pending[PEND_TIMER] = 1'b1;
                refresh = 1'b1;
            end
            OP_REQ_RESET: begin
                n_pending[PEND_RESET] = 1'b1;
                refresh = 1'b1;
            end
            OP_BUS_WRITE: begin
                n_pending = r_pending & ~i_ack.mask;
                refresh   = i_ack.hit;
            end
            default: ;
        endcase
    end

    assign grant = (i_req.op == OP_TAKE) && (r_level != '0)
                && ((r_level == LVL_TOP && r_edge) || (r_level > i_req.cpu_mask));

    always_comb begin
        n_level  = r_level;
        n_vector = r_vector;
        n_edge   = r_edge;
        if (refresh) begin
            n_edge = 1'b0;
            if (n_pending[PEND_RESET]) begin
                n_level  = LVL_RESET;
                n_vector = VEC_RESET;
            end else if (n_pending[PEND_TIMER]) begin
                n_level  = LVL_TIMER;
                n_vector = VEC_TIMER;
            end else if (n_pending[PEND_VBLANK]) begin
                n_level  = LVL_VBLANK;
                n_vector = VEC_VBLANK;
            end else begin
                n_level  = '0;
                n_vector = '0;
            end
        end else begin
            case (i_req.op)
                OP_TAKE: begin
                    if (grant && r_level == LVL_TOP && r_edge) begin
                        n_edge = 1'b0;
                    end
                end
                OP_SET_LEVEL: begin
                    n_level  = i_req.new_level;
                    n_vector = i_req.new_vector;
                    if (i_req.new_level == LVL_TOP && r_level != LVL_TOP) begin
                        n_edge = 1'b1;
                    end else if (i_req.new_level != LVL_TOP) begin
                        n_edge = 1'b0;
                    end
                end
                OP_CLR_LEVEL: begin
                    n_level  = '0;
                    n_vector = '0;
                    n_edge   = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_result.granted        = grant;
        o_result.granted_level  = grant ? r_level : '0;
        o_result.granted_vector = grant ? r_vector : '0;
        o_result.level_now      = n_level;
        o_result.vector_now     = n_vector;
        o_result.pending_now    = n_pending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_level   <= '0;
            r_vector  <= '0;
            r_edge    <= 1'b0;
        end else if (i_advance) begin
            r_pending <= n_pending;
            r_level   <= n_level;
            r_vector  <= n_vector;
            r_edge    <= n_edge;
        end
    end

    a_edge_only_at_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge |-> r_level == LVL_TOP)
        else $error("edge flag set below level 7");

    a_grant_keeps_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.granted |-> (o_result.granted_level == o_result.level_now
                              && o_result.granted_vector == o_result.vector_now))
        else $error("grant changed the presented interrupt");

    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_result.granted |-> (o_result.granted_level == '0
                               && o_result.granted_vector == '0))
        else $error("grant fields nonzero without grant");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> ($stable(r_pending) && $stable(r_level) && $stable(r_edge)))
        else $error("state changed without a request");

endmodule

>>> sv/interrupt_priority_controller.sv
// interrupt priority controller top level: request register, state, result register
// depends on ipc_pkg, ipc_ack_decode, ipc_state
//
// channel  direction  ports                 contents
// s_axis   in         tvalid tready tdata   request fields, operation in tuser
// m_axis   out        tvalid tready tdata   result fields, grant flag in tuser
//
// one request per cycle sustained while m_axis_tready holds; a result passes through the
// request register, then the result register, and is formed between them by the single
// state update stage
// synchronous active-low reset clears pending bits, level, vector and edge flag
// a stalled output holds the result register; the request register keeps filling
// until both stages are full, then s_axis_tready drops
module interrupt_priority_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // address, write_data, access_size, cpu_mask, new_level, new_vector
    input  logic [ipc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // operation
    input  logic [ipc_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // granted_level, granted_vector, level_now, vector_now, pending_now, zero fill
    output logic [ipc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // granted
    output logic                              m_axis_tuser
);
    import ipc_pkg::*;

    logic    r_in_valid;
    t_req    r_req;
    t_req    n_req;
    logic    r_out_valid;
    t_result r_out;
    t_result result;
    t_ack    ack;
    logic    advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_comb begin
        n_req.op          = t_op'(s_axis_tuser);
        n_req.address     = s_axis_tdata[23:0];
        n_req.write_data  = s_axis_tdata[55:24];
        n_req.access_size = t_size'(s_axis_tdata[57:56]);
        n_req.cpu_mask    = s_axis_tdata[60:58];
        n_req.new_level   = s_axis_tdata[63:61];
        n_req.new_vector  = s_axis_tdata[71:64];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_req <= n_req;
        end
    end

    ipc_ack_decode u_ack_decode (
        .i_address     (r_req.address),
        .i_write_data  (r_req.write_data),
        .i_access_size (r_req.access_size),
        .o_ack         (ack)
    );

    ipc_state u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_req     (r_req),
        .i_ack     (ack),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.granted;
    assign m_axis_tdata  = {7'd0, r_out.pending_now, r_out.vector_now, r_out.level_now,
                            r_out.granted_vector, r_out.granted_level};

endmodule

>>> sim/testbench.sv
// self-checking testbench for interrupt_priority_controller
// predicts every result from its own model of the pending bits, level, vector and edge flag
// depends on ipc_pkg and interrupt_priority_controller
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ipc_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 6;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]   s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tuser;

    interrupt_priority_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // predicted controller state
    logic [PEND_W-1:0] pend_bits = '0;
    logic [LVL_W-1:0]  cur_level = '0;
    logic [VEC_W-1:0]  cur_vector = '0;
    logic              top_armed = 1'b0;

    t_result due_results[$];
    int  error_count = 0;
    int  request_count = 0;
    int  result_count = 0;
    int  grant_count = 0;
    int  idle_cycles = 0;
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void present_level(logic [LVL_W-1:0] lvl, logic [VEC_W-1:0] vec);
        if (lvl == LVL_TOP && cur_level < LVL_TOP) begin
            top_armed = 1'b1;
        end else if (lvl < LVL_TOP) begin
            top_armed = 1'b0;
        end
        cur_level  = lvl;
        cur_vector = vec;
    endfunction

    function automatic void drop_level();
        cur_level  = '0;
        cur_vector = '0;
        top_armed  = 1'b0;
    endfunction

    function automatic void follow_priority();
        if (pend_bits[PEND_RESET]) begin
            present_level(LVL_RESET, VEC_RESET);
        end else if (pend_bits[PEND_TIMER]) begin
            present_level(LVL_TIMER, VEC_TIMER);
        end else if (pend_bits[PEND_VBLANK]) begin
            present_level(LVL_VBLANK, VEC_VBLANK);
        end else begin
            drop_level();
        end
    endfunction

    function automatic void acknowledge(logic [PEND_W-1:0] bits);
        pend_bits = pend_bits & ~bits;
        follow_priority();
    endfunction

    function automatic void bus_byte(logic [ADDR_W-1:0] addr, logic [7:0] value);
        if (addr == ACK_ADDR_HI) begin
            acknowledge(value[PEND_W-1:0]);
        end
    endfunction

    function automatic void bus_word(logic [ADDR_W-1:0] addr, logic [15:0] value);
        if (addr == ACK_ADDR) begin
            acknowledge(value[PEND_W-1:0]);
        end else begin
            bus_byte(addr, value[15:8]);
            bus_byte(addr + 24'd1, value[7:0]);
        end
    endfunction

    function automatic t_result predict_result(t_req r);
        t_result res;
        res = '0;
        case (r.op)
            OP_REQ_VBLANK: begin
                pend_bits[PEND_VBLANK] = 1'b1;
                follow_priority();
            end
            OP_REQ_TIMER: begin
                pend_bits[PEND_TIMER] = 1'b1;
                follow_priority();
            end
            OP_REQ_RESET: begin
                pend_bits[PEND_RESET] = 1'b1;
                follow_priority();
            end
            OP_BUS_WRITE: begin
                case (r.access_size)
                    SIZE_BYTE: bus_byte(r.address, r.write_data[7:0]);
                    SIZE_WORD: bus_word(r.address, r.write_data[15:0]);
                    SIZE_LONG: begin
                        bus_word(r.address, r.write_data[31:16]);
                        bus_word(r.address + 24'd2, r.write_data[15:0]);
                    end
                    default: ;
                endcase
            end
            OP_TAKE: begin
                if (cur_level != '0) begin
                    if (cur_level == LVL_TOP && top_armed) begin
                        top_armed   = 1'b0;
                        res.granted = 1'b1;
                    end else if (cur_level > r.cpu_mask) begin
                        res.granted = 1'b1;
                    end
                    if (res.granted) begin
                        res.granted_level  = cur_level;
                        res.granted_vector = cur_vector;
                    end
                end
            end
            OP_SET_LEVEL: present_level(r.new_level, r.new_vector);
            OP_CLR_LEVEL: drop_level();
            default: ;
        endcase
        res.level_now   = cur_level;
        res.vector_now  = cur_vector;
        res.pending_now = pend_bits;
        return res;
    endfunction

    task automatic send_request(t_req r);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.new_vector, r.new_level, r.cpu_mask, r.access_size,
                          r.write_data, r.address};
        s_axis_tuser  <= r.op;
        do @(posedge i_clk); while (!s_axis_tready);
        due_results.push_back(predict_result(r));
        request_count++;
    endtask

    function automatic t_req make_req(t_op op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data,
                                      t_size size, logic [LVL_W-1:0] mask,
                                      logic [LVL_W-1:0] lvl, logic [VEC_W-1:0] vec);
        t_req r;
        r.op          = op;
        r.address     = addr;
        r.write_data  = data;
        r.access_size = size;
        r.cpu_mask    = mask;
        r.new_level   = lvl;
        r.new_vector  = vec;
        return r;
    endfunction

    function automatic t_req random_fields();
        return make_req(t_op'($urandom_range(0, 7)), 24'($urandom), $urandom,
                        t_size'($urandom_range(0, 3)), 3'($urandom), 3'($urandom),
                        8'($urandom));
    endfunction

    // mostly near the acknowledge register so byte, word and long splits hit it
    function automatic logic [ADDR_W-1:0] near_ack_addr();
        if ($urandom_range(0, 3) == 0) begin
            return 24'($urandom);
        end
        return ACK_ADDR - 24'd3 + 24'($urandom_range(0, 5));
    endfunction

    function automatic void set_steady(int i);
        tx_steady = (i % 200) < 40;
        rx_steady = ((i + 100) % 200) < 40;
    endfunction

    task automatic test_directed_cases();
        send_request(make_req(OP_TAKE, '0, '0, SIZE_BYTE, 3'd0, 3'd0, 8'd0));
        send_request(make_req(OP_REQ_VBLANK, '0, '0, SIZE_BYTE, 3'd0, 3'd0, 8'd0));
        send_request(make_req(OP_TAKE, '0, '0, SIZE_BYTE, 3'd0, 3'd0, 8'd0));
        send_request(make_req(OP_REQ_TIMER, '0, '0, SIZE_BYTE, 3'd0, 3'd0, 8'd0));
        send_request(make_req(OP_REQ_RESET, '0, '0, SIZE_BYTE, 3'd0, 3'd0, 8'd0));
        send_request(make_req(OP_TAKE, '0, '0, SIZE_BYTE, 3'd3, 3'd0, 8'd0));
        send_request(make_req(OP_TAKE, '0, '0, SIZE_BYTE, 3'd2, 3'd0, 8'd0));
        send_request(make_req(OP_BUS_WRITE, ACK_ADDR, 32'h0001, SIZE_WORD, 3'd0, 3'd0, 8'd0));
        send_request(make_req(OP_BUS_WRITE, ACK_ADDR_HI, 32'h02, SIZE_BYTE, 3'd0, 3'd0, 8'd0));
        send_request(make_req(OP_REQ_RESET, '0, '0, SIZE_BYTE, 3'd0, 3'd0, 8'd0));
        // word at the odd address acknowledges with its high byte
        send_request(make_req(OP_BUS_WRITE, ACK_ADDR_HI, 32'h0100, SIZE_WORD, 3'd0, 3'd0, 8'd0));
        send_request(make_req(OP_BUS_WRITE, ACK_ADDR, 32'h0, SIZE_WORD, 3'd0, 3'd0, 8'd0));
        send_request(make_req(OP_BUS_WRITE, ACK_ADDR - 24'd2, 32'h0000_0004, SIZE_LONG,
                              3'd0, 3'd0, 8'd0));
        send_request(make_req(OP_REQ_TIMER, '0, '0, SIZE_BYTE, 3'd0, 3'd0, 8'd0));
        send_request(make_req(OP_BUS_WRITE, ACK_ADDR, 32'h0002_FFF8, SIZE_LONG, 3'd0, 3'd0, 8'd0));
        send_request(make_req(OP_REQ_VBLANK, '0, '0, SIZE_BYTE, 3'd0, 3'd0, 8'd0));
        send_request(make_req(OP_BUS_WRITE, ACK_ADDR - 24'd1, 32'h0000_0400, SIZE_LONG,
                              3'd0, 3'd0, 8'd0));
        send_request(make_req(OP_REQ_TIMER, '0, '0, SIZE_BYTE, 3'd0, 3'd0, 8'd0));
        send_request(make_req(OP_BUS_WRITE, ACK_ADDR, '1, SIZE_NONE, 3'd7, 3'd7, 8'hFF));
        send_request(make_req(OP_BUS_WRITE, 24'hFFFFFE, '1, SIZE_LONG, 3'd7, 3'd7, 8'hFF));
        send_request(make_req(OP_BUS_WRITE, ACK_ADDR, 32'hFF, SIZE_BYTE, 3'd0, 3'd0, 8'd0));
        send_request(make_req(OP_NONE, '1, '1, SIZE_NONE, 3'd7, 3'd7, 8'hFF));
        send_request(make_req(OP_SET_LEVEL, '0, '0, SIZE_BYTE, 3'd0, 3'd7, 8'hFF));
        send_request(make_req(OP_TAKE, '0, '0, SIZE_BYTE, 3'd7, 3'd0, 8'd0));
        send_request(make_req(OP_TAKE, '0, '0, SIZE_BYTE, 3'd7, 3'd0, 8'd0));
        send_request(make_req(OP_TAKE, '0, '0, SIZE_BYTE, 3'd6, 3'd0, 8'd0));
        send_request(make_req(OP_SET_LEVEL, '0, '0, SIZE_BYTE, 3'd0, 3'd7, 8'h80));
        send_request(make_req(OP_TAKE, '0, '0, SIZE_BYTE, 3'd7, 3'd0, 8'd0));
        send_request(make_req(OP_SET_LEVEL, '0, '0, SIZE_BYTE, 3'd0, 3'd6, 8'h00));
        send_request(make_req(OP_SET_LEVEL, '0, '0, SIZE_BYTE, 3'd0, 3'd7, 8'h5A));
        send_request(make_req(OP_TAKE, '0, '0, SIZE_BYTE, 3'd7, 3'd0, 8'd0));
        send_request(make_req(OP_CLR_LEVEL, '0, '0, SIZE_BYTE, 3'd0, 3'd0, 8'd0));
        send_request(make_req(OP_TAKE, '0, '0, SIZE_BYTE, 3'd0, 3'd0, 8'd0));
    endtask

    task automatic test_pending_and_ack(int count);
        t_req r;
        int   pick;
        for (int i = 0; i < count; i++) begin
            set_steady(i);
            r    = random_fields();
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                r.op = t_op'($urandom_range(0, 2));
            end else if (pick < 75) begin
                r.op          = OP_BUS_WRITE;
                r.address     = near_ack_addr();
                r.access_size = t_size'($urandom_range(0, 2));
            end else if (pick < 95) begin
                r.op = OP_TAKE;
            end else if (pick < 98) begin
                r.op = OP_NONE;
            end else begin
                r.op          = OP_BUS_WRITE;
                r.address     = near_ack_addr();
                r.access_size = SIZE_NONE;
            end
            send_request(r);
        end
    endtask

    task automatic test_direct_level(int count);
        t_req r;
        int   pick;
        for (int i = 0; i < count; i++) begin
            set_steady(i);
            r    = random_fields();
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                r.op = OP_SET_LEVEL;
                if ($urandom_range(0, 1)) begin
                    r.new_level = LVL_TOP;
                end
            end else if (pick < 80) begin
                r.op = OP_TAKE;
                if ($urandom_range(0, 2) == 0) begin
                    r.cpu_mask = 3'd7;
                end
            end else if (pick < 90) begin
                r.op = OP_CLR_LEVEL;
            end else begin
                r.op = t_op'($urandom_range(0, 2));
            end
            send_request(r);
        end
    endtask

    task automatic test_mixed_traffic(int count);
        t_req r;
        for (int i = 0; i < count; i++) begin
            set_steady(i);
            r = random_fields();
            if (r.op == OP_BUS_WRITE) begin
                r.address = near_ack_addr();
            end
            send_request(r);
        end
    endtask

    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    function automatic void compare_field(string name, int unsigned expected, int unsigned actual);
        if (expected != actual) begin
            $display("%0t %s expected %0h actual %0h", $time, name, expected, actual);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t watchdog: no handshake for %0d cycles", $time, idle_cycles);
                $display("interrupt_priority_controller: mismatch");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                result_count++;
                if (m_axis_tuser) begin
                    grant_count++;
                end
                if (due_results.size() == 0) begin
                    $display("%0t unexpected result expected none actual %h/%b",
                             $time, m_axis_tdata, m_axis_tuser);
                    error_count++;
                end else begin
                    exp_res = due_results.pop_front();
                    compare_field("granted", exp_res.granted, m_axis_tuser);
                    compare_field("granted_level", exp_res.granted_level, m_axis_tdata[2:0]);
                    compare_field("granted_vector", exp_res.granted_vector, m_axis_tdata[10:3]);
                    compare_field("level_now", exp_res.level_now, m_axis_tdata[13:11]);
                    compare_field("vector_now", exp_res.vector_now, m_axis_tdata[21:14]);
                    compare_field("pending_now", exp_res.pending_now, m_axis_tdata[24:22]);
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_pending_and_ack(800);
        test_direct_level(600);
        test_mixed_traffic(600);
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d requests covering requests, acknowledges, takes and level changes",
                 request_count);
        $display("checked %0d results, %0d of them grants, %0d field errors",
                 result_count, grant_count, error_count);
        if (error_count == 0 && due_results.size() == 0) begin
            $display("interrupt_priority_controller: match");
        end else begin
            $display("interrupt_priority_controller: mismatch");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/ipc_pkg.sv
sv/ipc_ack_decode.sv
sv/ipc_state.sv
sv/interrupt_priority_controller.sv
sim/testbench.sv
